### src/stream_skew_pause_tracker_core_defines.svh
// Assertion macros used by the tracker core.
// The enclosing module must provide clk and arst_n.
`ifndef STREAM_SKEW_PAUSE_TRACKER_CORE_DEFINES_SVH
`define STREAM_SKEW_PAUSE_TRACKER_CORE_DEFINES_SVH

`define SSPT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define SSPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/sspt_pkg.sv
package sspt_pkg;

	localparam logic [15:0] GAP_LIMIT_RESET    = 16'd10;
	localparam logic [3:0]  SOURCE_COUNT_RESET = 4'd8;

	localparam logic [2:0] ADDR_GAP_LIMIT    = 3'h0;
	localparam logic [2:0] ADDR_SOURCE_COUNT = 3'h4;

	localparam logic CMD_ARRIVAL = 1'b0;
	localparam logic CMD_CLEAR   = 1'b1;

	localparam int IDX_W = 6;

	typedef struct packed {
		logic arrive;
		logic clear;
		logic update;
	} sspt_ctrl_t;

endpackage

### src/sspt_cell.sv
module sspt_cell #(
	parameter int CHUNK_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sspt_pkg::sspt_ctrl_t   ctrl,
	input  logic                   sel,
	input  logic                   in_use,
	input  logic [CHUNK_BITS-1:0]  chunk,
	input  logic [15:0]            gap_limit,
	input  logic [CHUNK_BITS-1:0]  slow_min,
	input  logic                   prev_vld,
	input  logic [CHUNK_BITS-1:0]  prev_min,
	output logic                   vld_q,
	output logic [CHUNK_BITS-1:0]  min_q,
	output logic                   pause_q,
	output logic                   raise
);
	import sspt_pkg::*;

	localparam int DW = (CHUNK_BITS > 16) ? CHUNK_BITS : 16;

	logic [CHUNK_BITS-1:0] highest_q;
	logic [CHUNK_BITS-1:0] diff;
	logic                  own;
	logic                  take_own;
	logic                  lead_over;

	assign raise     = ctrl.arrive && sel && (chunk > highest_q);
	assign own       = in_use && (highest_q != '0);
	assign take_own  = own && (!prev_vld || (highest_q < prev_min));
	assign diff      = highest_q - slow_min;
	assign lead_over = DW'(diff) > DW'(gap_limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			highest_q <= '0;
			pause_q   <= 1'b0;
			vld_q     <= 1'b0;
			min_q     <= '0;
		end else begin
			if (raise) begin
				highest_q <= chunk;
			end
			if (ctrl.clear && sel) begin
				pause_q <= 1'b0;
			end else if (ctrl.update && in_use) begin
				pause_q <= (highest_q != '0) && lead_over;
			end
			vld_q <= prev_vld || own;
			min_q <= take_own ? highest_q : prev_min;
		end
	end

endmodule

### src/stream_skew_pause_tracker_core.sv
// Skew and pause tracker: each request on the slave stream either reports a chunk
// arrival or clears one source's pause flag, and produces exactly one result on the
// master stream. Every source has a cell in a chain; the running minimum of the
// nonzero highest chunk numbers passes one cell per clock. Each request goes through
// acceptance, a scan while the minimum crosses the chain, the pause update and the
// output load, which waits for m_tready when a result is still held; the next request
// is taken as soon as the result has moved into the output register. State is cleared
// by reset directly; there is no clearing pass.
module stream_skew_pause_tracker_core #(
	parameter int MAX_SOURCES = 8,
	parameter int CHUNK_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // source_index [2:0], chunk_number [34:3], zero [39:35]
	input  logic [0:0]  s_tuser,  // cmd [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// paused_mask [7:0], slowest_highest [39:8], slowest_valid [40],
	// new_highest [41], unknown_source [42], zero [47:43]
	output logic [47:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sspt_pkg::*;

	`include "stream_skew_pause_tracker_core_defines.svh"

	localparam int CW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_PAUSE = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]            state_q;
	logic [CW-1:0]         cnt_q;
	logic [15:0]           gap_limit_q;
	logic [3:0]            source_count_q;
	logic                  raised_q;
	logic                  unknown_q;
	logic                  m_valid_q;
	logic [47:0]           m_data_q;

	logic                  accept;
	logic                  cfg_write;
	logic                  s_cmd;
	logic [2:0]            s_idx;
	logic [31:0]           s_chunk;
	logic [CHUNK_BITS-1:0] chunk_c;
	logic                  unknown;
	logic                  load_out;
	sspt_ctrl_t            ctrl;

	logic [MAX_SOURCES-1:0] sel;
	logic [MAX_SOURCES-1:0] in_use;
	logic [MAX_SOURCES-1:0] raise_vec;
	logic [MAX_SOURCES-1:0] pause_vec;
	logic [MAX_SOURCES-1:0] vld_chain;
	logic [CHUNK_BITS-1:0]  min_chain [MAX_SOURCES];

	logic [CHUNK_BITS-1:0] slow_min;
	logic                  slow_vld;
	logic [31:0]           slow32;
	logic [7:0]            mask8;

	assign s_cmd   = s_tuser[0];
	assign s_idx   = s_tdata[2:0];
	assign s_chunk = s_tdata[34:3];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign unknown  = (IDX_W'(s_idx) >= IDX_W'(source_count_q)) ||
		(IDX_W'(s_idx) >= IDX_W'(MAX_SOURCES));

	assign ctrl.arrive = accept && !unknown && (s_cmd == CMD_ARRIVAL);
	assign ctrl.clear  = accept && !unknown && (s_cmd == CMD_CLEAR);
	assign ctrl.update = (state_q == ST_PAUSE) && raised_q && slow_vld;

	generate
		if (CHUNK_BITS <= 32) begin : g_chunk_narrow
			assign chunk_c = s_chunk[CHUNK_BITS-1:0];
		end else begin : g_chunk_wide
			assign chunk_c = {{(CHUNK_BITS-32){1'b0}}, s_chunk};
		end
		if (CHUNK_BITS >= 32) begin : g_out_wide
			assign slow32 = slow_min[31:0];
		end else begin : g_out_narrow
			assign slow32 = {{(32-CHUNK_BITS){1'b0}}, slow_min};
		end
	endgenerate

	assign slow_min = min_chain[MAX_SOURCES-1];
	assign slow_vld = vld_chain[MAX_SOURCES-1];

	generate
		for (genvar i = 0; i < MAX_SOURCES; i++) begin : g_cell
			logic                  prev_vld;
			logic [CHUNK_BITS-1:0] prev_min;

			assign sel[i]    = (IDX_W'(s_idx) == IDX_W'(i));
			assign in_use[i] = (IDX_W'(i) < IDX_W'(source_count_q));

			if (i == 0) begin : g_head
				assign prev_vld = 1'b0;
				assign prev_min = '0;
			end else begin : g_link
				assign prev_vld = vld_chain[i-1];
				assign prev_min = min_chain[i-1];
			end

			sspt_cell #(
				.CHUNK_BITS(CHUNK_BITS)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.sel      (sel[i]),
				.in_use   (in_use[i]),
				.chunk    (chunk_c),
				.gap_limit(gap_limit_q),
				.slow_min (slow_min),
				.prev_vld (prev_vld),
				.prev_min (prev_min),
				.vld_q    (vld_chain[i]),
				.min_q    (min_chain[i]),
				.pause_q  (pause_vec[i]),
				.raise    (raise_vec[i])
			);
		end

		for (genvar b = 0; b < 8; b++) begin : g_mask
			if (b < MAX_SOURCES) begin : g_bit
				assign mask8[b] = pause_vec[b] && in_use[b];
			end else begin : g_zero
				assign mask8[b] = 1'b0;
			end
		end
	endgenerate

	assign load_out = (state_q == ST_DONE) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			raised_q  <= 1'b0;
			unknown_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						raised_q  <= |raise_vec;
						unknown_q <= unknown;
						cnt_q     <= '0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q == CW'(MAX_SOURCES - 1)) begin
						state_q <= ST_PAUSE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_PAUSE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_data_q <= {5'b0, unknown_q, raised_q, slow_vld,
				(slow_vld ? slow32 : 32'b0), mask8};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q    <= GAP_LIMIT_RESET;
			source_count_q <= SOURCE_COUNT_RESET;
		end else if (cfg_write) begin
			unique case (paddr)
				ADDR_GAP_LIMIT:    gap_limit_q    <= pwdata[15:0];
				ADDR_SOURCE_COUNT: source_count_q <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_GAP_LIMIT:    prdata = {16'b0, gap_limit_q};
			ADDR_SOURCE_COUNT: prdata = {28'b0, source_count_q};
			default:           prdata = 32'b0;
		endcase
	end

	`SSPT_ASSERT_NOW(a_raise_known, m_tvalid && m_tdata[41], !m_tdata[42], "raise reported for unknown source")
	`SSPT_ASSERT_NOW(a_raise_has_min, m_tvalid && m_tdata[41], m_tdata[40], "raise without a valid minimum")
	`SSPT_ASSERT_NEXT(a_scan_to_pause, (state_q == ST_SCAN) && (cnt_q == CW'(MAX_SOURCES - 1)), state_q == ST_PAUSE, "scan did not end in pause update")

endmodule

### test/tb_stream_skew_pause_tracker_core.sv
module tb_stream_skew_pause_tracker_core;
	timeunit 1ns;
	timeprecision 1ps;

	import sspt_pkg::*;

	typedef struct packed {
		logic        unknown_source;
		logic        new_highest;
		logic        slowest_valid;
		logic [31:0] slowest_highest;
		logic [7:0]  paused_mask;
	} tracker_result_t;

	class pause_scoreboard;
		bit [31:0] highest [8];
		bit pause [8];
		bit [15:0] gap_limit;
		bit [3:0] source_count;
		tracker_result_t expected_results [$];
		int errors;

		function new();
			for (int i = 0; i < 8; i++) begin
				highest[i] = '0;
				pause[i] = 1'b0;
			end
			gap_limit = GAP_LIMIT_RESET;
			source_count = SOURCE_COUNT_RESET;
			errors = 0;
		endfunction

		function void report_mismatch(string what);
			if (errors < 100)
				$display("mismatch at %0t: %s", $time, what);
			errors++;
		endfunction

		function void find_slowest(input int n, output bit found, output bit [31:0] m);
			found = 1'b0;
			m = '0;
			for (int i = 0; i < n; i++) begin
				if (highest[i] != 0 && (!found || highest[i] < m)) begin
					m = highest[i];
					found = 1'b1;
				end
			end
		endfunction

		function void rescan_pauses(input int n);
			bit found;
			bit [31:0] m;
			find_slowest(n, found, m);
			if (found) begin
				for (int i = 0; i < n; i++)
					pause[i] = (highest[i] != 0) && ((highest[i] - m) > {16'b0, gap_limit});
			end
		endfunction

		function void note_request(logic cmd, logic [2:0] idx, logic [31:0] chunk);
			tracker_result_t r;
			int n;
			bit found;
			bit [31:0] m;
			n = (source_count > 8) ? 8 : source_count;
			r = '0;
			r.unknown_source = (idx >= n);
			if (!r.unknown_source) begin
				if (cmd == CMD_ARRIVAL) begin
					if (chunk > highest[idx]) begin
						highest[idx] = chunk;
						r.new_highest = 1'b1;
						rescan_pauses(n);
					end
				end else begin
					pause[idx] = 1'b0;
				end
			end
			for (int i = 0; i < n; i++)
				r.paused_mask[i] = pause[i];
			find_slowest(n, found, m);
			r.slowest_valid = found;
			r.slowest_highest = found ? m : '0;
			expected_results.insert(expected_results.size(), r);
		endfunction

		function void check_result(logic [47:0] data);
			tracker_result_t got;
			tracker_result_t want;
			got = tracker_result_t'(data[42:0]);
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result 0x%h with no request pending", data));
				return;
			end
			want = expected_results.pop_front();
			if (got.paused_mask !== want.paused_mask)
				report_mismatch($sformatf("paused_mask 0x%h, want 0x%h",
					got.paused_mask, want.paused_mask));
			if (got.slowest_highest !== want.slowest_highest)
				report_mismatch($sformatf("slowest_highest 0x%h, want 0x%h",
					got.slowest_highest, want.slowest_highest));
			if (got.slowest_valid !== want.slowest_valid)
				report_mismatch($sformatf("slowest_valid %b, want %b",
					got.slowest_valid, want.slowest_valid));
			if (got.new_highest !== want.new_highest)
				report_mismatch($sformatf("new_highest %b, want %b",
					got.new_highest, want.new_highest));
			if (got.unknown_source !== want.unknown_source)
				report_mismatch($sformatf("unknown_source %b, want %b",
					got.unknown_source, want.unknown_source));
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	pause_scoreboard sb;
	int sink_idle_pct = 0;
	int sink_stall = 0;
	logic [31:0] frontier = 32'd200;

	stream_skew_pause_tracker_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready)
			sb.check_result(m_tdata);
		if (sink_stall > 0) begin
			sink_stall <= sink_stall - 1;
			m_tready <= 1'b0;
		end else if (sink_idle_pct > 0 && $urandom_range(99) < sink_idle_pct) begin
			sink_stall <= $urandom_range(17);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic configure(input logic [15:0] gap, input logic [3:0] count);
		logic [31:0] rd;
		wait_drained();
		apb_access(1'b1, ADDR_GAP_LIMIT, {16'b0, gap}, rd);
		apb_access(1'b0, ADDR_GAP_LIMIT, '0, rd);
		if (rd !== {16'b0, gap})
			sb.report_mismatch($sformatf("gap_limit reads 0x%h, want 0x%h", rd, gap));
		apb_access(1'b1, ADDR_SOURCE_COUNT, {28'b0, count}, rd);
		apb_access(1'b0, ADDR_SOURCE_COUNT, '0, rd);
		if (rd !== {28'b0, count})
			sb.report_mismatch($sformatf("source_count reads 0x%h, want 0x%h", rd, count));
		sb.gap_limit = gap;
		sb.source_count = count;
	endtask

	task automatic send_request(input logic cmd, input logic [2:0] idx, input logic [31:0] chunk,
			input int idle_pct);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {5'b0, chunk, idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_request(cmd, idx, chunk);
	endtask

	task automatic random_phase(input logic [15:0] gap, input logic [3:0] count, input int items,
			input int src_pct, input int snk_pct, input bit to_top);
		int n;
		int sel;
		int spread;
		logic cmd;
		logic [2:0] idx;
		logic [32:0] wide;
		configure(gap, count);
		sink_idle_pct = snk_pct;
		if (to_top)
			frontier = 32'hFFFF_FFE0;
		else
			frontier = frontier + $urandom_range(32'h00FF_FFFF);
		n = (count > 8) ? 8 : count;
		spread = (gap > 200) ? 400 : 2 * gap + 4;
		for (int k = 0; k < items; k++) begin
			sel = $urandom_range(99);
			cmd = CMD_ARRIVAL;
			idx = (n > 0) ? 3'($urandom_range(n - 1)) : 3'($urandom_range(7));
			if (sel < 65) begin
				wide = {1'b0, frontier} + 33'($urandom_range(spread));
			end else if (sel < 72) begin
				wide = {1'b0, frontier} + {17'b0, gap} + 33'($urandom_range(2));
			end else if (sel < 82) begin
				cmd = CMD_CLEAR;
				idx = 3'($urandom_range(7));
				wide = {1'b0, 32'($urandom())};
			end else if (sel < 90) begin
				idx = 3'($urandom_range(7));
				if (idx < n)
					wide = {1'b0, 32'($urandom_range(frontier))};
				else
					wide = {1'b0, 32'($urandom())};
			end else if (sel < 95) begin
				wide = {1'b0, sb.highest[idx]};
			end else begin
				wide = '0;
			end
			if ($urandom_range(99) < 30 && frontier < 32'hFFFF_FFF0)
				frontier = frontier + $urandom_range(3);
			send_request(cmd, idx, wide[32] ? 32'hFFFF_FFFF : wide[31:0], src_pct);
		end
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sink_idle_pct = 5;
		send_request(CMD_ARRIVAL, 3'd0, 32'd0, 0);
		send_request(CMD_CLEAR, 3'd3, 32'hFFFF_FFFF, 0);
		send_request(CMD_ARRIVAL, 3'd0, 32'd5, 0);
		send_request(CMD_ARRIVAL, 3'd1, 32'd16, 0);
		send_request(CMD_ARRIVAL, 3'd2, 32'd15, 0);
		send_request(CMD_ARRIVAL, 3'd1, 32'd16, 0);
		send_request(CMD_ARRIVAL, 3'd1, 32'd3, 0);
		send_request(CMD_CLEAR, 3'd1, 32'd0, 0);
		send_request(CMD_ARRIVAL, 3'd0, 32'd6, 0);
		send_request(CMD_ARRIVAL, 3'd3, 32'd100, 0);
		send_request(CMD_ARRIVAL, 3'd7, 32'd1, 0);
		send_request(CMD_ARRIVAL, 3'd4, 32'd1000, 0);
		send_request(CMD_CLEAR, 3'd4, 32'h5A5A_5A5A, 0);
		configure(16'd10, 4'd4);
		send_request(CMD_ARRIVAL, 3'd5, 32'd50, 0);
		send_request(CMD_ARRIVAL, 3'd3, 32'd101, 0);
		send_request(CMD_CLEAR, 3'd6, 32'd0, 0);
		configure(16'd0, 4'd0);
		send_request(CMD_ARRIVAL, 3'd0, 32'd7, 0);
		send_request(CMD_CLEAR, 3'd0, 32'd0, 0);
		configure(16'd0, 4'd15);
		send_request(CMD_ARRIVAL, 3'd7, 32'd2, 0);
		send_request(CMD_ARRIVAL, 3'd5, 32'd3, 0);
		send_request(CMD_ARRIVAL, 3'd6, 32'd9, 0);
		configure(16'hFFFF, 4'd8);
		send_request(CMD_ARRIVAL, 3'd2, 32'd65537, 0);
		send_request(CMD_ARRIVAL, 3'd1, 32'd65538, 0);

		random_phase(16'd10, 4'd8, 120, 30, 6, 1'b0);
		random_phase(16'd0, 4'd8, 100, 0, 0, 1'b0);
		random_phase(16'hFFFF, 4'd8, 80, 20, 8, 1'b0);
		random_phase(16'd3, 4'd1, 60, 30, 4, 1'b0);
		random_phase(16'd5, 4'd15, 100, 40, 0, 1'b0);
		random_phase(16'd0, 4'd0, 30, 10, 3, 1'b0);
		random_phase(16'($urandom_range(40)), 4'd4, 100, 30, 6, 1'b0);
		random_phase(16'($urandom_range(40)), 4'd6, 100, 0, 6, 1'b0);
		random_phase(16'($urandom()), 4'($urandom_range(1, 8)), 100, 30, 6, 1'b0);
		random_phase(16'($urandom_range(20)), 4'd8, 120, 25, 5, 1'b0);
		random_phase(16'd2, 4'd8, 120, 0, 0, 1'b1);

		wait_drained();
		repeat (24) @(posedge clk);
		if (sb.expected_results.size() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived",
				sb.expected_results.size()));
		if (sb.errors == 0)
			$display("tb_stream_skew_pause_tracker_core passed");
		else
			$display("tb_stream_skew_pause_tracker_core failed");
		$finish;
	end

	initial begin
		#10ms;
		$display("tb_stream_skew_pause_tracker_core failed");
		$finish;
	end

endmodule
